// ===== rtl/orb_pkg.sv =====
// shared types and constants of the overwriting ring buffer
package orb_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 5;
	localparam int CNT_W  = 5;
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_NONE     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_PUSH       = 2'd0,
		CMD_SHIFT      = 2'd1,
		CMD_ITER_START = 2'd2,
		CMD_ITER_NEXT  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage

// ===== rtl/overwriting_ring_buffer.sv =====
// top level of the overwriting ring buffer
//
// A ring of capacity+1 slots in one synchronous RAM. A command is taken when
// start is high and busy is low; busy then stays high for exactly one cycle.
// The accept cycle reads the slot at the head or cursor (and a push writes
// its word at the tail), and the busy cycle uses the read data, writes back
// a cleared slot on shift or eviction and moves the pointers. The result
// word appears with done for one cycle, in the cycle after busy, while the
// next command can already be taken. The receiver cannot hold results off.
// No new command is taken while busy, since the RAM read is registered and
// the busy cycle holds the write-back. Writing the capacity register empties
// the ring; the user must write it only while the block is idle, and the
// block itself does not enforce this.
module overwriting_ring_buffer #(
	parameter int DEPTH       = orb_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = orb_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  cmd,
	input  logic [orb_pkg::WORD_W-1:0]  entry_in,
	output logic                        busy,
	output logic                        done,
	output logic [orb_pkg::WORD_W-1:0]  entry_out,
	output logic                        found,
	output logic                        dropped,
	output logic [orb_pkg::CNT_W-1:0]   count,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [orb_pkg::ADDR_W-1:0]  paddr,
	input  logic [orb_pkg::PDATA_W-1:0] pwdata,
	output logic [orb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int SLOTS = DEPTH + 1;
	localparam int PTR_W = $clog2(SLOTS);

	orb_pkg::state_t state_q, state_d;
	orb_pkg::cmd_t   cmd_s1;

	logic [orb_pkg::CAP_W-1:0] capacity_q;
	logic [PTR_W-1:0] head_q, tail_q, cursor_q;
	logic [PTR_W-1:0] head_d, tail_d, cursor_d;
	logic [PTR_W-1:0] cap_eff;
	logic [PTR_W-1:0] tail_bump, head_bump, cursor_bump;
	logic [PTR_W-1:0] held;

	logic accept, exec, cfg_wr;
	logic clr_s1;
	logic [ENTRY_WIDTH-1:0] value_d;
	logic found_d, dropped_d;

	logic                   ram_we, ram_re;
	logic [PTR_W-1:0]       ram_waddr, ram_raddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                        done_q, found_q, dropped_q;
	logic [orb_pkg::WORD_W-1:0]  entry_out_q;
	logic [orb_pkg::CNT_W-1:0]   count_q;

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (orb_pkg::reg_idx_t'(paddr[2]) == orb_pkg::REG_CAPACITY);

	// effective capacity, clamped to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = PTR_W'(1);
		end else if (32'(capacity_q) > 32'(DEPTH)) begin
			cap_eff = PTR_W'(DEPTH);
		end else begin
			cap_eff = PTR_W'(capacity_q);
		end
	end

	assign tail_bump   = (tail_q == cap_eff) ? '0 : tail_q + PTR_W'(1);
	assign head_bump   = (head_q == cap_eff) ? '0 : head_q + PTR_W'(1);
	assign cursor_bump = (cursor_q == cap_eff) ? '0 : cursor_q + PTR_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			orb_pkg::ST_IDLE: begin
				if (accept) state_d = orb_pkg::ST_EXEC;
			end
			orb_pkg::ST_EXEC: begin
				state_d = orb_pkg::ST_IDLE;
			end
			default: begin
				state_d = orb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			orb_pkg::ST_IDLE: begin
				busy = 1'b0;
				exec = 1'b0;
			end
			orb_pkg::ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	// write-back step, using the slot read at accept
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		cursor_d  = cursor_q;
		value_d   = '0;
		found_d   = 1'b0;
		dropped_d = 1'b0;
		clr_s1    = 1'b0;
		case (cmd_s1)
			orb_pkg::CMD_PUSH: begin
				tail_d = tail_bump;
				if (tail_bump == head_q) begin
					value_d   = ram_rdata;
					head_d    = head_bump;
					dropped_d = 1'b1;
					clr_s1    = exec;
				end
			end
			orb_pkg::CMD_SHIFT: begin
				if (head_q != tail_q) begin
					value_d = ram_rdata;
					head_d  = head_bump;
					found_d = 1'b1;
					clr_s1  = exec;
				end
			end
			orb_pkg::CMD_ITER_START: begin
				cursor_d = head_q;
			end
			orb_pkg::CMD_ITER_NEXT: begin
				if (cursor_q != tail_q) begin
					value_d  = ram_rdata;
					cursor_d = cursor_bump;
					found_d  = 1'b1;
				end
			end
			default: begin
				head_d = head_q;
			end
		endcase
	end

	assign held = (tail_d >= head_d) ? (tail_d - head_d)
		: (cap_eff + PTR_W'(1) - head_d + tail_d);

	assign ram_we    = (accept && (cmd == orb_pkg::CMD_PUSH)) || clr_s1;
	assign ram_waddr = clr_s1 ? head_q : tail_q;
	assign ram_wdata = clr_s1 ? '0 : ENTRY_WIDTH'(entry_in);
	assign ram_re    = accept;
	assign ram_raddr = (cmd == orb_pkg::CMD_ITER_NEXT) ? cursor_q : head_q;

	orb_ram #(
		.WORDS  (SLOTS),
		.DATA_W (ENTRY_WIDTH),
		.AW     (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= orb_pkg::ST_IDLE;
			capacity_q <= orb_pkg::CAP_RESET;
			head_q     <= '0;
			tail_q     <= '0;
			cursor_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= exec;
			if (cfg_wr) begin
				capacity_q <= pwdata[orb_pkg::CAP_W-1:0];
				head_q     <= '0;
				tail_q     <= '0;
				cursor_q   <= '0;
			end else if (exec) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				cursor_q <= cursor_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= orb_pkg::cmd_t'(cmd);
		end
		if (exec) begin
			entry_out_q <= orb_pkg::WORD_W'(value_d);
			found_q     <= found_d;
			dropped_q   <= dropped_d;
			count_q     <= orb_pkg::CNT_W'(held);
		end
	end

	assign done      = done_q;
	assign entry_out = entry_out_q;
	assign found     = found_q;
	assign dropped   = dropped_q;
	assign count     = count_q;

	assign pready = 1'b1;
	assign prdata = (orb_pkg::reg_idx_t'(paddr[2]) == orb_pkg::REG_CAPACITY)
		? orb_pkg::PDATA_W'(capacity_q) : '0;

endmodule

// ===== rtl/orb_ram.sv =====
// slot memory: one write port, one registered read port
module orb_ram #(
	parameter int WORDS  = orb_pkg::DEPTH_DEF + 1,
	parameter int DATA_W = orb_pkg::ENTRY_WIDTH_DEF,
	parameter int AW     = $clog2(orb_pkg::DEPTH_DEF + 1)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/orb_checker.sv =====
// port-level checks of the overwriting ring buffer, bound to the top level
module orb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        found,
	input logic                        dropped,
	input logic [orb_pkg::CNT_W-1:0]   count
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("busy cycle not followed by result");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding busy cycle");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && dropped) && (!dropped || (count != '0)))
		else $error("inconsistent result flags");

endmodule

bind overwriting_ring_buffer orb_checker u_orb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.found   (found),
	.dropped (dropped),
	.count   (count)
);
